FILE: rtl/core/lstt_pkg.sv
// Package for the leveled software timer table: sizes, request codes,
// the slot record layout and the event record. No dependencies.
`default_nettype none

package lstt_pkg;

  // Table geometry
  localparam int ENTRIES    = 16;
  localparam int LEVELS     = 3;
  localparam int TICK_WIDTH = 16;

  localparam int NSLOTS = LEVELS * ENTRIES;
  localparam int ADDR_W = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);

  // Field widths of the beats
  localparam int REQ_W   = 2;
  localparam int LEVEL_W = 2;
  localparam int ID_W    = 8;
  localparam int SLOT_W  = 4;
  localparam int COUNT_W = 16;

  typedef logic [TICK_WIDTH-1:0] tick_t;
  typedef logic [ADDR_W-1:0]     addr_t;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_STOP  = 2'd2,
    REQ_SET   = 2'd3
  } req_e;

  // One timer slot as stored in the table memory
  typedef struct packed {
    logic [ID_W-1:0] id;
    tick_t           delay;
    tick_t           period;
    logic            periodic;
    logic            running;
    tick_t           remaining;
  } slot_rec_t;

  // One result beat
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [ID_W-1:0]    id;
    logic [SLOT_W-1:0]  slot;
    logic               has_event;
    logic               last;
  } evt_t;

endpackage

`default_nettype wire

FILE: rtl/core/lstt_if.sv
// Stream interfaces of the timer table: request channel and event channel.
// Depends on lstt_pkg for the field widths.
`default_nettype none

interface lstt_req_if
  import lstt_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [LEVEL_W-1:0] level;
  logic [ID_W-1:0]    timer_id;
  logic [SLOT_W-1:0]  slot;
  logic [COUNT_W-1:0] delay;
  logic [COUNT_W-1:0] period;
  logic               periodic;

  modport source (output valid, req_type, level, timer_id, slot, delay, period, periodic,
                  input ready);
  modport sink   (input valid, req_type, level, timer_id, slot, delay, period, periodic,
                  output ready);
endinterface

interface lstt_evt_if
  import lstt_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] event_level;
  logic [ID_W-1:0]    event_id;
  logic [SLOT_W-1:0]  event_slot;
  logic               has_event;
  logic               last;

  modport source (output valid, event_level, event_id, event_slot, has_event, last,
                  input ready);
  modport sink   (input valid, event_level, event_id, event_slot, has_event, last,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/leveled_software_timer_table.sv
// Top level of the leveled software timer table: slot memory, scan sequencer
// and event output register. Depends on lstt_pkg and the lstt_if interfaces.
//
//   channel | dir | beat
//   --------+-----+-----------------------------------------------------------
//   req_i   | in  | req_type, level, timer_id, slot, delay, period, periodic
//   evt_o   | out | event_level, event_id, event_slot, has_event, last
//
// Tick, start and stop walk the level's ENTRIES slots through the slot memory
// (one read, one write port), one slot a cycle unless an event stall holds it.
// Set entry and requests for an unknown level skip the walk and go to done.
// A held event beat stalls the walk only when a second expiry finds no room.
// Reset clears per-slot valid bits at once; an unwritten slot reads as zero.
// One request is in work at a time; req_i is ready only between requests.
`default_nettype none

module leveled_software_timer_table
  import lstt_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  lstt_req_if.sink    req_i,
  lstt_evt_if.source  evt_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  localparam logic [2:0] LEVELS_C  = 3'(LEVELS);
  localparam logic [6:0] ENTRIES_C = 7'(ENTRIES);

  state_e            state_q, state_d;
  req_e              op_q, op_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [LEVEL_W-1:0] lvl_q, lvl_d;
  addr_t             base_q, base_d;
  logic              found_q, found_d;
  logic [CNT_W-1:0]  rd_cnt_q, rd_cnt_d;
  logic              proc_vld_q, proc_vld_d;
  logic [IDX_W-1:0]  proc_idx_q, proc_idx_d;
  evt_t              pend_q, pend_d;
  logic              pend_vld_q, pend_vld_d;
  evt_t              out_q, out_d;
  logic              out_vld_q, out_vld_d;

  // Slot memory and its valid bits
  slot_rec_t         mem_q [NSLOTS];
  logic [NSLOTS-1:0] vld_q;
  slot_rec_t         rdata_q;
  logic              rd_vld_q;

  logic              re, we;
  addr_t             raddr, waddr;
  slot_rec_t         wdata;

  logic              req_acc, lvl_ok, slot_ok;
  slot_rec_t         rec, rec_new;
  tick_t             dec;
  logic              expire, match, stall, out_free;
  evt_t              new_evt;

  assign req_acc  = req_i.valid && req_i.ready;
  assign lvl_ok   = {1'b0, req_i.level} < LEVELS_C;
  assign slot_ok  = {3'b000, req_i.slot} < ENTRIES_C;
  assign out_free = !out_vld_q || evt_o.ready;
  assign rec      = rd_vld_q ? rdata_q : '0;

  // Per-slot update for the walk
  always_comb begin
    rec_new = rec;
    dec     = (rec.remaining != '0) ? rec.remaining - tick_t'(1) : rec.remaining;
    expire  = 1'b0;
    match   = (rec.id == id_q) && !found_q;
    case (op_q)
      REQ_TICK: begin
        if (rec.running) begin
          rec_new.remaining = dec;
          if (dec == '0) begin
            expire = 1'b1;
            if (rec.periodic) begin
              rec_new.remaining = rec.period;
            end else begin
              rec_new.running = 1'b0;
            end
          end
        end
      end
      REQ_START: begin
        rec_new.remaining = rec.delay;
        rec_new.running   = 1'b1;
      end
      REQ_STOP: begin
        rec_new.remaining = '0;
        rec_new.running   = 1'b0;
      end
      default: begin
        rec_new = rec;
      end
    endcase
    expire = expire && proc_vld_q && (state_q == ST_SCAN);
  end

  assign new_evt = '{level: lvl_q, id: rec.id, slot: SLOT_W'(proc_idx_q),
                     has_event: 1'b1, last: 1'b0};
  assign stall   = expire && pend_vld_q && !out_free;

  // Memory port control
  always_comb begin
    re    = (state_q == ST_SCAN) && !stall && (rd_cnt_q < CNT_W'(ENTRIES));
    raddr = base_q + addr_t'(rd_cnt_q[IDX_W-1:0]);
    we    = 1'b0;
    waddr = base_q + addr_t'(proc_idx_q);
    wdata = rec_new;
    if (state_q == ST_IDLE) begin
      we    = req_acc && (req_e'(req_i.req_type) == REQ_SET) && lvl_ok && slot_ok;
      waddr = addr_t'(req_i.level * ENTRIES + req_i.slot);
      wdata = '{id: req_i.timer_id, delay: tick_t'(req_i.delay),
                period: tick_t'(req_i.period), periodic: req_i.periodic,
                running: 1'b0, remaining: '0};
    end else if ((state_q == ST_SCAN) && proc_vld_q && !stall) begin
      we = (op_q == REQ_TICK) || match;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q  <= mem_q[raddr];
      rd_vld_q <= vld_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we) begin
      vld_q[waddr] <= 1'b1;
    end
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    id_d       = id_q;
    lvl_d      = lvl_q;
    base_d     = base_q;
    found_d    = found_q;
    rd_cnt_d   = rd_cnt_q;
    proc_vld_d = proc_vld_q;
    proc_idx_d = proc_idx_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q;

    if (out_vld_q && evt_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          op_d     = req_e'(req_i.req_type);
          id_d     = req_i.timer_id;
          lvl_d    = req_i.level;
          base_d   = addr_t'(req_i.level * ENTRIES);
          found_d  = 1'b0;
          rd_cnt_d = '0;
          if (lvl_ok && (req_e'(req_i.req_type) != REQ_SET)) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          if (proc_vld_q && match && (op_q != REQ_TICK)) begin
            found_d = 1'b1;
          end
          if (expire) begin
            if (pend_vld_q) begin
              out_d     = pend_q;
              out_vld_d = 1'b1;
            end
            pend_d     = new_evt;
            pend_vld_d = 1'b1;
          end
          proc_vld_d = re;
          proc_idx_d = rd_cnt_q[IDX_W-1:0];
          if (re) begin
            rd_cnt_d = rd_cnt_q + CNT_W'(1);
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          if (pend_vld_q) begin
            out_d      = pend_q;
            out_d.last = 1'b1;
          end else begin
            out_d = '{level: '0, id: '0, slot: '0, has_event: 1'b0, last: 1'b1};
          end
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      found_q    <= 1'b0;
      rd_cnt_q   <= '0;
      proc_vld_q <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      found_q    <= found_d;
      rd_cnt_q   <= rd_cnt_d;
      proc_vld_q <= proc_vld_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    id_q       <= id_d;
    lvl_q      <= lvl_d;
    base_q     <= base_d;
    proc_idx_q <= proc_idx_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
  end

  // Ports
  assign req_i.ready       = (state_q == ST_IDLE);
  assign evt_o.valid       = out_vld_q;
  assign evt_o.event_level = out_q.level;
  assign evt_o.event_id    = out_q.id;
  assign evt_o.event_slot  = out_q.slot;
  assign evt_o.has_event   = out_q.has_event;
  assign evt_o.last        = out_q.last;

endmodule

`default_nettype wire

FILE: rtl/core/lstt_checker.sv
// Port-level checks for the leveled software timer table, and the bind
// that attaches them. Depends on lstt_pkg.
`default_nettype none

module lstt_checker
  import lstt_pkg::*;
(
  input wire               clk_i,
  input wire               rst_ni,
  input wire               req_valid_i,
  input wire               req_ready_i,
  input wire               evt_valid_i,
  input wire               evt_ready_i,
  input wire [LEVEL_W-1:0] evt_level_i,
  input wire [ID_W-1:0]    evt_id_i,
  input wire [SLOT_W-1:0]  evt_slot_i,
  input wire               evt_has_event_i,
  input wire               evt_last_i
);

  // A stalled event beat stays put
  a_evt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && !evt_ready_i |=> evt_valid_i && $stable(evt_id_i) && $stable(evt_last_i))
    else $error("event beat changed while stalled");

  // An acknowledgment beat always closes its request
  a_ack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && !evt_has_event_i |-> evt_last_i)
    else $error("acknowledgment beat without last");

  // An acknowledgment beat carries zero fields
  a_ack_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && !evt_has_event_i |->
      (evt_level_i == '0) && (evt_id_i == '0) && (evt_slot_i == '0))
    else $error("acknowledgment beat with nonzero fields");

  // Events only come from a real level
  a_evt_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && evt_has_event_i |-> {1'b0, evt_level_i} < 3'(LEVELS))
    else $error("event from an unknown level");

  // One request in work at a time
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while another is in work");

endmodule

bind leveled_software_timer_table lstt_checker u_lstt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .evt_valid_i     (evt_o.valid),
  .evt_ready_i     (evt_o.ready),
  .evt_level_i     (evt_o.event_level),
  .evt_id_i        (evt_o.event_id),
  .evt_slot_i      (evt_o.event_slot),
  .evt_has_event_i (evt_o.has_event),
  .evt_last_i      (evt_o.last)
);

`default_nettype wire
